/* hdl/pvst_pkg.sv */
// ----------------------------------------------------------------------------
// pvst_pkg: shared types and constants of the pump and valve session timer
// Command codes, register indexes, the timer state record and limit values.
// ----------------------------------------------------------------------------
`default_nettype none

package pvst_pkg;

  localparam int unsigned MsW  = 11;
  localparam int unsigned SecW = 16;

  localparam logic [MsW-1:0]  MS_PER_SECOND = 11'd1000;
  localparam logic [MsW-1:0]  TICK_MS_MAX   = 11'd1000;
  localparam logic [SecW-1:0] SEC_MAX       = 16'hFFFF;
  localparam logic [SecW-1:0] LIMIT_RESET   = 16'd3600;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_ACTIVATE = 3'd1,
    MODE_PUMP_ON  = 3'd2,
    MODE_PUMP_OFF = 3'd3,
    MODE_LOCK     = 3'd4,
    MODE_UNLOCK   = 3'd5,
    MODE_TOGGLE   = 3'd6,
    MODE_END      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    CFG_PUMP_LIMIT    = 2'd0,
    CFG_SESSION_LIMIT = 2'd1,
    CFG_FAILSAFE      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [SecW-1:0] pump_limit;
    logic [SecW-1:0] session_limit;
    logic [SecW-1:0] failsafe;
  } limits_t;

  typedef struct packed {
    logic            pump_active;
    logic            valve_active;
    logic [MsW-1:0]  pump_ms_accum;
    logic [SecW-1:0] pump_sec_count;
    logic [MsW-1:0]  session_ms_accum;
    logic [SecW-1:0] session_sec_count;
    logic            lockout;
  } state_t;

  typedef struct packed {
    logic pump_status;
    logic valve_status;
    logic pump_time;
    logic session_time;
  } report_t;

  typedef struct packed {
    logic            carry;
    logic [MsW-1:0]  ms_accum;
    logic [SecW-1:0] sec_count;
  } accum_t;

endpackage

`default_nettype wire

/* hdl/pump_valve_session_timer_unit.sv */
// ----------------------------------------------------------------------------
// pump_valve_session_timer_unit: pump and valve run-time controller
// Input register, one pass of next-state logic, result register.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    mode, elapsed_ms
//   out       source     out_valid / out_ready  pump_on .. failsafe_tripped
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle is sustained while the result register can advance; an
// item waits in the input register until the result register loads its result.
// Reset clears the timer state and loads 3600 into every limit register.
// A stalled result holds the pipe; the input register still takes an item
// while the result register is full and being drained. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_valve_session_timer_unit
  import pvst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [9:0]  elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pump_on,
  output logic             valve_locked,
  output logic [15:0]      pump_seconds,
  output logic [15:0]      session_seconds,
  output logic             pump_status_report,
  output logic             valve_status_report,
  output logic             pump_time_report,
  output logic             session_time_report,
  output logic             failsafe_tripped,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  limits_t     limits;
  logic        in_full;
  mode_t       in_mode;
  logic [9:0]  in_ms;
  state_t      state;
  state_t      state_next;
  report_t     rep;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !in_full || advance;

  pvst_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  pvst_step u_step (
    .cur        (state),
    .limits     (limits),
    .mode       (in_mode),
    .elapsed_ms (in_ms),
    .nxt        (state_next),
    .rep        (rep)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_mode <= mode_t'(mode);
      in_ms   <= elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
      if (in_full) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      pump_on             <= state_next.pump_active;
      valve_locked        <= state_next.valve_active;
      pump_seconds        <= state_next.pump_sec_count;
      session_seconds     <= state_next.session_sec_count;
      pump_status_report  <= rep.pump_status;
      valve_status_report <= rep.valve_status;
      pump_time_report    <= rep.pump_time;
      session_time_report <= rep.session_time;
      failsafe_tripped    <= state_next.lockout;
    end
  end

endmodule

`default_nettype wire

/* hdl/pvst_regs.sv */
// ----------------------------------------------------------------------------
// pvst_regs: limit registers
// Holds the pump, session and failsafe limits written over the config port.
// ----------------------------------------------------------------------------
`default_nettype none

module pvst_regs
  import pvst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output limits_t          limits
);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.pump_limit    <= LIMIT_RESET;
      limits.session_limit <= LIMIT_RESET;
      limits.failsafe      <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PUMP_LIMIT:    limits.pump_limit    <= cfg_data;
        CFG_SESSION_LIMIT: limits.session_limit <= cfg_data;
        CFG_FAILSAFE:      limits.failsafe      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pvst_step.sv */
// ----------------------------------------------------------------------------
// pvst_step: next-state logic for one item
// Applies a tick or a command to the timer state and raises report flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pvst_step
  import pvst_pkg::*;
(
  input  state_t          cur,
  input  limits_t         limits,
  input  mode_t           mode,
  input  wire logic [9:0] elapsed_ms,
  output state_t          nxt,
  output report_t         rep
);

  // The accumulator never exceeds one second and a tick is at most one
  // second, so at most one whole second is carried per tick.
  function automatic accum_t accumulate(logic [MsW-1:0] acc, logic [SecW-1:0] secs,
                                        logic [MsW-1:0] ms);
    accum_t          r;
    logic [MsW-1:0]  sum;
    sum         = acc + ms;
    r.carry     = 1'b0;
    r.ms_accum  = sum;
    r.sec_count = secs;
    if (sum > MS_PER_SECOND) begin
      r.carry     = 1'b1;
      r.ms_accum  = sum - MS_PER_SECOND;
      r.sec_count = (secs == SEC_MAX) ? SEC_MAX : secs + 16'd1;
    end
    return r;
  endfunction

  logic [MsW-1:0] tick_ms;
  accum_t         pump_acc;
  accum_t         sess_acc;

  always_comb begin
    tick_ms  = ({1'b0, elapsed_ms} > TICK_MS_MAX) ? TICK_MS_MAX : {1'b0, elapsed_ms};
    pump_acc = accumulate(cur.pump_ms_accum, cur.pump_sec_count, tick_ms);
    sess_acc = accumulate(cur.session_ms_accum, cur.session_sec_count, tick_ms);
    nxt      = cur;
    rep      = '0;

    if (!cur.lockout) begin
      case (mode)
        MODE_TICK: begin
          if (cur.pump_active) begin
            nxt.pump_ms_accum  = pump_acc.ms_accum;
            nxt.pump_sec_count = pump_acc.sec_count;
            rep.pump_time      = pump_acc.carry;
            if (pump_acc.sec_count >= limits.pump_limit) begin
              nxt.pump_active    = 1'b0;
              nxt.pump_ms_accum  = '0;
              nxt.pump_sec_count = '0;
              rep.pump_status    = 1'b1;
              rep.pump_time      = 1'b1;
            end
          end
          if (cur.valve_active) begin
            nxt.session_ms_accum  = sess_acc.ms_accum;
            nxt.session_sec_count = sess_acc.sec_count;
            rep.session_time      = sess_acc.carry;
            // The session limit wins over the failsafe; both end the session.
            if (sess_acc.sec_count >= limits.session_limit ||
                sess_acc.sec_count >= limits.failsafe) begin
              nxt.pump_active       = 1'b0;
              nxt.pump_ms_accum     = '0;
              nxt.pump_sec_count    = '0;
              nxt.valve_active      = 1'b0;
              nxt.session_ms_accum  = '0;
              nxt.session_sec_count = '0;
              rep.pump_status       = 1'b1;
              rep.pump_time         = 1'b1;
              rep.valve_status      = 1'b1;
              nxt.lockout = (sess_acc.sec_count < limits.session_limit);
            end
          end
        end
        MODE_ACTIVATE: begin
          nxt.pump_active  = 1'b1;
          rep.pump_status  = !cur.pump_active;
          nxt.valve_active = 1'b1;
          rep.valve_status = 1'b1;
        end
        MODE_PUMP_ON: begin
          nxt.pump_active = 1'b1;
          rep.pump_status = !cur.pump_active;
        end
        MODE_PUMP_OFF: begin
          nxt.pump_active    = 1'b0;
          nxt.pump_ms_accum  = '0;
          nxt.pump_sec_count = '0;
          rep.pump_status    = 1'b1;
          rep.pump_time      = 1'b1;
        end
        MODE_LOCK: begin
          nxt.valve_active = 1'b1;
          rep.valve_status = 1'b1;
        end
        MODE_UNLOCK: begin
          nxt.valve_active = 1'b0;
          rep.valve_status = 1'b1;
        end
        MODE_TOGGLE: begin
          nxt.valve_active = !cur.valve_active;
          rep.valve_status = 1'b1;
        end
        default: begin
          nxt.pump_active       = 1'b0;
          nxt.pump_ms_accum     = '0;
          nxt.pump_sec_count    = '0;
          nxt.valve_active      = 1'b0;
          nxt.session_ms_accum  = '0;
          nxt.session_sec_count = '0;
          rep.pump_status       = 1'b1;
          rep.pump_time         = 1'b1;
          rep.valve_status      = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/pvst_checker.sv */
// ----------------------------------------------------------------------------
// pvst_checker: port-level checks of the session timer
// Watches result transfers for lockout, pump count and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module pvst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        pump_on,
  input wire logic        valve_locked,
  input wire logic [15:0] pump_seconds,
  input wire logic [15:0] session_seconds,
  input wire logic        failsafe_tripped
);

  logic out_xfer;
  logic tripped_seen;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tripped_seen <= 1'b0;
    end else if (out_xfer && failsafe_tripped) begin
      tripped_seen <= 1'b1;
    end
  end

  // A latched lockout forces both drives off and both counts to zero.
  a_lockout_quiet: assert property (@(posedge clk) disable iff (rst)
    out_xfer && failsafe_tripped |->
      !pump_on && !valve_locked && pump_seconds == 16'd0 && session_seconds == 16'd0)
    else $error("lockout result shows activity");

  // Once a transfer has shown the lockout, only a reset clears it.
  a_lockout_sticky: assert property (@(posedge clk) disable iff (rst)
    out_xfer && tripped_seen |-> failsafe_tripped)
    else $error("lockout dropped without reset");

  // The pump count is cleared whenever the pump is off.
  a_pump_count_idle: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !pump_on |-> pump_seconds == 16'd0)
    else $error("pump count nonzero while pump is off");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pump_seconds) &&
      $stable(session_seconds) && $stable(failsafe_tripped))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pump_valve_session_timer_unit pvst_checker u_pvst_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .pump_on          (pump_on),
  .valve_locked     (valve_locked),
  .pump_seconds     (pump_seconds),
  .session_seconds  (session_seconds),
  .failsafe_tripped (failsafe_tripped)
);

`default_nettype wire

/* dv/pump_valve_session_timer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pump_valve_session_timer_unit_tb: self-checking bench for the session timer
// Drives ticks and commands over the valid/ready input channel and checks
// every result against a predictor of the pump, valve and session counters.
// The limit registers are rewritten between phases, and the run ends with
// the failsafe lockout.
// ----------------------------------------------------------------------------

module pump_valve_session_timer_unit_tb;
  import pvst_pkg::*;

  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned TICK_CAP    = 1000;
  localparam int unsigned SEC_CAP     = 65535;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          IDLE_SETTLE = 4;
  localparam int          PHASE_ITEMS = 200;
  localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;

  typedef struct packed {
    logic        pump_on;
    logic        valve_locked;
    logic [15:0] pump_seconds;
    logic [15:0] session_seconds;
    logic        pump_status;
    logic        valve_status;
    logic        pump_time;
    logic        session_time;
    logic        failsafe;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mode_t       mode = MODE_TICK;
  logic [9:0]  elapsed_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        pump_on;
  logic        valve_locked;
  logic [15:0] pump_seconds;
  logic [15:0] session_seconds;
  logic        pump_status_report;
  logic        valve_status_report;
  logic        pump_time_report;
  logic        session_time_report;
  logic        failsafe_tripped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pump_valve_session_timer_unit uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .mode                (mode),
    .elapsed_ms          (elapsed_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .pump_on             (pump_on),
    .valve_locked        (valve_locked),
    .pump_seconds        (pump_seconds),
    .session_seconds     (session_seconds),
    .pump_status_report  (pump_status_report),
    .valve_status_report (valve_status_report),
    .pump_time_report    (pump_time_report),
    .session_time_report (session_time_report),
    .failsafe_tripped    (failsafe_tripped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  // Bench copy of the timer state and the limit registers.
  logic        pump_run = 1'b0;
  logic        valve_lock = 1'b0;
  logic        locked_out = 1'b0;
  int unsigned pump_ms = 0;
  int unsigned pump_sec = 0;
  int unsigned sess_ms = 0;
  int unsigned sess_sec = 0;
  logic [15:0] lim_pump = LIMIT_RESET;
  logic [15:0] lim_session = LIMIT_RESET;
  logic [15:0] lim_failsafe = LIMIT_RESET;
  logic        r_pump_status, r_valve_status, r_pump_time, r_session_time;

  status_t status_due[$];
  int      err_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;
  int      cycle_count = 0;
  logic    steady = 1'b0;
  int      sink_run = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [9:0] pick_tick_ms();
    case ($urandom_range(0, 9))
      0: return 10'($urandom_range(0, 1023));
      1: begin
        case ($urandom_range(0, 3))
          0: return 10'd999;
          1: return 10'd1000;
          2: return 10'd1001;
          default: return 10'd1023;
        endcase
      end
      default: return 10'($urandom_range(600, 1023));
    endcase
  endfunction

  // Adds milliseconds to an accumulator and carries whole seconds, but only
  // once the sum is strictly above one second.
  task automatic add_ms(inout int unsigned acc, inout int unsigned secs,
                        input int unsigned ms, output logic carry);
    int unsigned sum, whole;
    sum = acc + ms;
    carry = (sum > MS_PER_SEC);
    if (carry) begin
      whole = (sum - 1) / MS_PER_SEC;
      acc = sum - whole * MS_PER_SEC;
      secs = (secs + whole > SEC_CAP) ? SEC_CAP : secs + whole;
    end else begin
      acc = sum;
    end
  endtask

  task automatic start_pump();
    if (!pump_run) begin
      pump_run = 1'b1;
      r_pump_status = 1'b1;
    end
  endtask

  task automatic stop_pump();
    pump_run = 1'b0;
    pump_ms = 0;
    pump_sec = 0;
    r_pump_status = 1'b1;
    r_pump_time = 1'b1;
  endtask

  task automatic set_valve(input logic lock);
    valve_lock = lock;
    r_valve_status = 1'b1;
  endtask

  task automatic end_session();
    stop_pump();
    set_valve(1'b0);
    sess_ms = 0;
    sess_sec = 0;
  endtask

  task automatic predict_status(input mode_t m, input logic [9:0] ms_field,
                                output status_t st);
    int unsigned ms;
    logic carry;
    r_pump_status = 1'b0;
    r_valve_status = 1'b0;
    r_pump_time = 1'b0;
    r_session_time = 1'b0;
    ms = (ms_field > TICK_CAP) ? TICK_CAP : ms_field;
    if (!locked_out) begin
      case (m)
        MODE_TICK: begin
          if (pump_run) begin
            add_ms(pump_ms, pump_sec, ms, carry);
            if (carry) r_pump_time = 1'b1;
            if (pump_sec >= lim_pump) stop_pump();
          end
          if (valve_lock) begin
            add_ms(sess_ms, sess_sec, ms, carry);
            if (carry) r_session_time = 1'b1;
            // The normal session limit wins over the failsafe ceiling.
            if (sess_sec >= lim_session) begin
              end_session();
            end else if (sess_sec >= lim_failsafe) begin
              end_session();
              locked_out = 1'b1;
            end
          end
        end
        MODE_ACTIVATE: begin
          start_pump();
          set_valve(1'b1);
        end
        MODE_PUMP_ON:  start_pump();
        MODE_PUMP_OFF: stop_pump();
        MODE_LOCK:     set_valve(1'b1);
        MODE_UNLOCK:   set_valve(1'b0);
        MODE_TOGGLE:   set_valve(!valve_lock);
        default:       end_session();
      endcase
    end
    st.pump_on = pump_run;
    st.valve_locked = valve_lock;
    st.pump_seconds = pump_sec[15:0];
    st.session_seconds = sess_sec[15:0];
    st.pump_status = r_pump_status;
    st.valve_status = r_valve_status;
    st.pump_time = r_pump_time;
    st.session_time = r_session_time;
    st.failsafe = locked_out;
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("mismatch on result %0d, %s: expected %0d, got %0d",
             results_seen, what, exp_v, got_v);
    err_count++;
  endtask

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v !== got_v) report_mismatch(what, exp_v, got_v);
  endtask

  // Sends one item. The valid stays high across back-to-back transfers.
  task automatic send_item(input mode_t m, input logic [9:0] ms);
    int gap;
    status_t st;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    elapsed_ms <= ms;
    do @(posedge clk); while (!in_ready);
    predict_status(m, ms, st);
    status_due.push_back(st);
    items_sent++;
  endtask

  task automatic send_any();
    send_item(mode_t'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PUMP_LIMIT:    lim_pump = val;
      CFG_SESSION_LIMIT: lim_session = val;
      CFG_FAILSAFE:      lim_failsafe = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Result sink: alternating runs of ready and stall cycles.
  always @(posedge clk) begin
    if (sink_run > 0) begin
      sink_run <= sink_run - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      sink_run <= pick_gap();
    end else begin
      out_ready <= 1'b1;
      sink_run <= $urandom_range(0, 40);
    end
  end

  always @(posedge clk) begin : result_check
    status_t exp_st;
    if (!rst && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", 0, 1);
      end else begin
        exp_st = status_due.pop_front();
        check_field("pump_on", exp_st.pump_on, pump_on);
        check_field("valve_locked", exp_st.valve_locked, valve_locked);
        check_field("pump_seconds", exp_st.pump_seconds, pump_seconds);
        check_field("session_seconds", exp_st.session_seconds, session_seconds);
        check_field("pump_status_report", exp_st.pump_status, pump_status_report);
        check_field("valve_status_report", exp_st.valve_status, valve_status_report);
        check_field("pump_time_report", exp_st.pump_time, pump_time_report);
        check_field("session_time_report", exp_st.session_time, session_time_report);
        check_field("failsafe_tripped", exp_st.failsafe, failsafe_tripped);
      end
      results_seen++;
    end
  end

  // Reset limits: commands, repeated commands and the one-second boundary.
  task automatic test_directed_basics();
    send_item(MODE_TICK, 10'd1023);
    send_item(MODE_ACTIVATE, 10'd0);
    send_item(MODE_TICK, 10'd1000);
    send_item(MODE_TICK, 10'd1);
    send_item(MODE_TICK, 10'd1023);
    send_item(MODE_PUMP_ON, 10'd555);
    send_item(MODE_TICK, 10'd0);
    send_item(MODE_TOGGLE, 10'd1023);
    send_item(MODE_TICK, 10'd999);
    send_item(MODE_TOGGLE, 10'd0);
    send_item(MODE_LOCK, 10'd0);
    send_item(MODE_UNLOCK, 10'd0);
    send_item(MODE_UNLOCK, 10'd341);
    send_item(MODE_PUMP_OFF, 10'd0);
    send_item(MODE_PUMP_OFF, 10'd682);
    send_item(MODE_PUMP_ON, 10'd0);
    send_item(MODE_LOCK, 10'd0);
    send_item(MODE_TICK, 10'd1001);
    send_item(MODE_END, 10'd1023);
    send_item(MODE_END, 10'd0);
    send_item(MODE_TICK, 10'd512);
  endtask

  // Zero limits stop the pump and end the session on the first tick.
  task automatic test_zero_limits();
    wait_idle();
    write_limit(CFG_PUMP_LIMIT, 16'd0);
    write_limit(CFG_SESSION_LIMIT, 16'd0);
    write_limit(CFG_FAILSAFE, 16'hFFFF);
    send_item(MODE_ACTIVATE, 10'd0);
    send_item(MODE_TICK, 10'd0);
    send_item(MODE_PUMP_ON, 10'd0);
    send_item(MODE_TICK, 10'd0);
    send_item(MODE_LOCK, 10'd0);
    send_item(MODE_TICK, 10'd1023);
    send_item(MODE_TOGGLE, 10'd0);
    send_item(MODE_TICK, 10'd0);
  endtask

  // Phases of random sessions under varied limits. The failsafe ceiling is
  // kept at or above the session limit so that no lockout happens here.
  task automatic test_random_sessions();
    int p, start, n, r;
    logic [15:0] pl, sl, fl;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin
          pl = 16'hFFFF;
          sl = 16'hFFFF;
          fl = 16'hFFFF;
        end
        1: begin
          pl = 16'd0;
          sl = 16'd1;
          fl = 16'd1;
        end
        default: begin
          pl = 16'($urandom_range(0, 20));
          sl = 16'($urandom_range(0, 30));
          fl = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
               16'(sl + $urandom_range(0, 4));
        end
      endcase
      wait_idle();
      write_limit(CFG_PUMP_LIMIT, pl);
      write_limit(CFG_SESSION_LIMIT, sl);
      write_limit(CFG_FAILSAFE, fl);
      if (p == 0) write_limit(CFG_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_any();
        end else begin
          r = $urandom_range(0, 9);
          if (r < 6) send_item(MODE_ACTIVATE, 10'($urandom_range(0, 1023)));
          else if (r < 8) send_item(MODE_LOCK, 10'($urandom_range(0, 1023)));
          else send_item(MODE_PUMP_ON, 10'($urandom_range(0, 1023)));
          n = $urandom_range(3, 40);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0)
              send_item(mode_t'($urandom_range(1, 7)), 10'($urandom_range(0, 1023)));
            else
              send_item(MODE_TICK, pick_tick_ms());
          end
          case ($urandom_range(0, 3))
            0: send_item(MODE_END, 10'($urandom_range(0, 1023)));
            1: send_item(MODE_UNLOCK, 10'($urandom_range(0, 1023)));
            2: send_item(MODE_PUMP_OFF, 10'($urandom_range(0, 1023)));
            default: ;
          endcase
        end
      end
      steady = 1'b0;
    end
  endtask

  // Failsafe ceiling below the session limit latches the lockout, which
  // only reset clears, so this runs last.
  task automatic test_failsafe_lockout();
    wait_idle();
    write_limit(CFG_PUMP_LIMIT, 16'd5);
    write_limit(CFG_SESSION_LIMIT, 16'd20);
    write_limit(CFG_FAILSAFE, 16'd3);
    send_item(MODE_ACTIVATE, 10'd0);
    repeat (8) send_item(MODE_TICK, 10'd1000);
    repeat (60) send_any();
    // Register writes are still taken during lockout.
    wait_idle();
    write_limit(CFG_FAILSAFE, 16'd0);
    write_limit(CFG_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
    repeat (40) send_any();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_zero_limits();
    test_random_sessions();
    test_failsafe_lockout();
    wait_idle();
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
